FILE: rtl/c8pd_pkg.sv
// Package for the CRC-8 packet deframer: phase codes, result word layout,
// CRC update function and register reset values. No dependencies.

package c8pd_pkg;

   // field widths of the channels: bytes and register indexes
   localparam int BYTE_W      = 8;
   localparam int CSR_INDEX_W = 2;

   // register indexes on the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_FIRST  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_SECOND = 2'd1;

   // register reset values
   localparam logic [BYTE_W-1:0] SYNC_FIRST_RESET  = 8'h54;
   localparam logic [BYTE_W-1:0] SYNC_SECOND_RESET = 8'h2C;

   // CRC-8, MSB first, no final xor
   localparam logic [BYTE_W-1:0] CRC_POLY = 8'h4D;
   localparam logic [BYTE_W-1:0] CRC_INIT = 8'h00;

   // result queue depth and its count width
   localparam int QUEUE_DEPTH = 4;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // deframer phase
   typedef enum logic [1:0] {
      PH_HUNT = 2'd0,
      PH_BODY = 2'd1,
      PH_CRC  = 2'd2
   } phase_type;

   // one result word
   typedef struct packed {
      logic [BYTE_W-1:0] frame_byte;
      logic [BYTE_W-1:0] byte_index;
      logic              is_last;
      logic              crc_ok;
   } rsp_type;

   // words handed to the result queue in one cycle (zero, one or two)
   typedef struct packed {
      logic [1:0] n;
      rsp_type    word0;
      rsp_type    word1;
   } push_type;

   // fold one byte into the running CRC
   function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                     input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] c;
      c = crc ^ b;
      for (int k = 0; k < BYTE_W; k++) begin
         if (c[BYTE_W-1]) begin
            c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[BYTE_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

FILE: rtl/c8pd_channels.sv
// Channel interfaces of the CRC-8 packet deframer: received bytes, frame
// results and register writes. Depends on c8pd_pkg.

interface c8pd_req_if import c8pd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface c8pd_rsp_if import c8pd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] frame_byte;
   logic [BYTE_W-1:0] byte_index;
   logic              is_last;
   logic              crc_ok;

   modport source (output valid, output frame_byte, output byte_index,
                   output is_last, output crc_ok, input ready);
   modport sink   (input valid, input frame_byte, input byte_index,
                   input is_last, input crc_ok, output ready);
endinterface

interface c8pd_csr_if import c8pd_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [BYTE_W-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/crc8_packet_deframer.sv
// Top level of the CRC-8 packet deframer: header hunt, frame byte count and
// running CRC-8. Depends on c8pd_pkg, c8pd_channels and c8pd_rsp_queue.
//
//   channel   dir  word                                           accepted when
//   req_bus   in   rx_byte                                        valid & ready
//   rsp_bus   out  frame_byte, byte_index, is_last, crc_ok        valid & ready
//   csr_bus   in   index (0 sync_first, 1 sync_second), data      valid & ready
//
// One received byte is taken per cycle while req_bus.ready is high; its results are in
// the result queue at the next edge, and a word reaches rsp_bus behind any older words.
// The header byte yields two words; the four-deep result queue absorbs them.
// req_bus.ready is low only while the result queue lacks room for two words.
// Reset is synchronous: hunting, queue empty, sync bytes 0x54 and 0x2C.
// csr_bus is always ready; a write takes effect at the next edge.

module crc8_packet_deframer import c8pd_pkg::*; #(
   parameter int FRAME_BYTES = 47
) (
   input  logic     clock,
   input  logic     reset,
   c8pd_req_if.sink req_bus,
   c8pd_rsp_if.source rsp_bus,
   c8pd_csr_if.sink csr_bus
);

   // index of the trailing CRC byte
   localparam logic [BYTE_W-1:0] LAST_IDX = BYTE_W'(FRAME_BYTES - 1);

   phase_type         phase_ff,       phase_in;
   logic              sync_seen_ff,   sync_seen_in;
   logic [BYTE_W-1:0] byte_count_ff,  byte_count_in;
   logic [BYTE_W-1:0] crc_ff,         crc_in;
   logic [BYTE_W-1:0] sync_first_ff,  sync_first_in;
   logic [BYTE_W-1:0] sync_second_ff, sync_second_in;
   logic [BYTE_W-1:0] hdr_crc_ff,     hdr_crc_in;
   logic              accept;
   logic              room;
   logic [BYTE_W-1:0] b;
   push_type          push;

   assign accept        = req_bus.valid & req_bus.ready;
   assign req_bus.ready = room;
   assign csr_bus.ready = 1'b1;
   assign b             = req_bus.rx_byte;

   // register writes; keep the CRC of the first header byte beside it
   always_comb begin
      sync_first_in  = sync_first_ff;
      sync_second_in = sync_second_ff;
      hdr_crc_in     = hdr_crc_ff;
      if (csr_bus.valid && csr_bus.ready) begin
         case (csr_bus.index)
            CSR_SYNC_FIRST: begin
               sync_first_in = csr_bus.data;
               hdr_crc_in    = crc8_update(CRC_INIT, csr_bus.data);
            end
            CSR_SYNC_SECOND: begin
               sync_second_in = csr_bus.data;
            end
            default: begin
               sync_first_in = sync_first_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= SYNC_FIRST_RESET;
         sync_second_ff <= SYNC_SECOND_RESET;
         hdr_crc_ff     <= crc8_update(CRC_INIT, SYNC_FIRST_RESET);
      end else begin
         sync_first_ff  <= sync_first_in;
         sync_second_ff <= sync_second_in;
         hdr_crc_ff     <= hdr_crc_in;
      end
   end

   // next phase, count, CRC and result words for the accepted byte
   always_comb begin
      phase_in      = phase_ff;
      sync_seen_in  = sync_seen_ff;
      byte_count_in = byte_count_ff;
      crc_in        = crc_ff;
      push          = '0;
      if (accept) begin
         case (phase_ff)
            PH_BODY: begin
               push.n                = 2'd1;
               push.word0.frame_byte = b;
               push.word0.byte_index = byte_count_ff;
               crc_in                = crc8_update(crc_ff, b);
               byte_count_in         = byte_count_ff + BYTE_W'(1);
               phase_in = (byte_count_in >= LAST_IDX) ? PH_CRC : PH_BODY;
            end
            PH_CRC: begin
               push.n                = 2'd1;
               push.word0.frame_byte = b;
               push.word0.byte_index = byte_count_ff;
               push.word0.is_last    = 1'b1;
               push.word0.crc_ok     = (crc_ff == b);
               phase_in              = PH_HUNT;
               sync_seen_in          = 1'b0;
               byte_count_in         = '0;
               crc_in                = CRC_INIT;
            end
            default: begin
               // hunt; the unused code lands here too
               phase_in = PH_HUNT;
               if (sync_seen_ff && (b == sync_second_ff)) begin
                  push.n                = 2'd2;
                  push.word0.frame_byte = sync_first_ff;
                  push.word0.byte_index = BYTE_W'(0);
                  push.word1.frame_byte = b;
                  push.word1.byte_index = BYTE_W'(1);
                  crc_in                = crc8_update(hdr_crc_ff, b);
                  byte_count_in         = BYTE_W'(2);
                  sync_seen_in          = 1'b0;
                  phase_in = (byte_count_in >= LAST_IDX) ? PH_CRC : PH_BODY;
               end else begin
                  sync_seen_in = (b == sync_first_ff);
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT;
         sync_seen_ff  <= 1'b0;
         byte_count_ff <= '0;
         crc_ff        <= CRC_INIT;
      end else begin
         phase_ff      <= phase_in;
         sync_seen_ff  <= sync_seen_in;
         byte_count_ff <= byte_count_in;
         crc_ff        <= crc_in;
      end
   end

   c8pd_rsp_queue u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .room    (room),
      .rsp_bus (rsp_bus)
   );

   a_crc_at_last: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_CRC) |-> (byte_count_ff == LAST_IDX))
      else $error("CRC phase away from the last byte");

   a_body_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_BODY) |-> (byte_count_ff >= BYTE_W'(2) && byte_count_ff < LAST_IDX))
      else $error("body byte count out of range");

   a_hunt_clean: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HUNT) |-> (byte_count_ff == '0 && crc_ff == CRC_INIT))
      else $error("hunting with stale frame state");

   a_crc_ends_frame: assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff == PH_CRC) |=> (phase_ff == PH_HUNT && !sync_seen_ff))
      else $error("frame did not end after the CRC byte");

endmodule

FILE: rtl/c8pd_rsp_queue.sv
// Result queue of the CRC-8 packet deframer: a short shift queue that takes
// up to two words a cycle and drives the result channel. Depends on c8pd_pkg
// and c8pd_channels.

module c8pd_rsp_queue import c8pd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   output logic       room,
   c8pd_rsp_if.source rsp_bus
);

   rsp_type           slot_ff [QUEUE_DEPTH];
   rsp_type           slot_in [QUEUE_DEPTH];
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;
   logic [QCNT_W-1:0] base_cnt;
   logic              pop;

   // head of the queue drives the channel
   assign pop                = rsp_bus.valid & rsp_bus.ready;
   assign rsp_bus.valid      = (count_ff != '0);
   assign rsp_bus.frame_byte = slot_ff[0].frame_byte;
   assign rsp_bus.byte_index = slot_ff[0].byte_index;
   assign rsp_bus.is_last    = slot_ff[0].is_last;
   assign rsp_bus.crc_ok     = slot_ff[0].crc_ok;

   // space for a two-word push whatever the sink does
   assign room = (count_ff <= QCNT_W'(QUEUE_DEPTH - 2));

   // shift on pop, then drop new words in behind the survivors
   always_comb begin
      base_cnt = count_ff - QCNT_W'(pop);
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (pop && (i < QUEUE_DEPTH - 1)) begin
            slot_in[i] = slot_ff[(i + 1) % QUEUE_DEPTH];
         end else begin
            slot_in[i] = slot_ff[i];
         end
         if ((push.n != 2'd0) && (QCNT_W'(i) == base_cnt)) begin
            slot_in[i] = push.word0;
         end
         if ((push.n == 2'd2) && (QCNT_W'(i) == base_cnt + QCNT_W'(1))) begin
            slot_in[i] = push.word1;
         end
      end
      count_in = base_cnt + QCNT_W'(push.n);
   end

   // hold the words
   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

   // fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push.n != 2'd0) |-> room)
      else $error("result queue pushed without room");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("result queue count beyond depth");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push.n == 2'd0 && !pop) |=> $stable(count_ff))
      else $error("result queue count moved without push or pop");

endmodule

FILE: tb/sv/crc8_packet_deframer_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for crc8_packet_deframer: a directed stimulus table, then random
// frames and line noise, every result word checked against its typed table row or a behavioural deframer.
// Depends on c8pd_pkg, c8pd_channels and the deframer RTL.

module crc8_packet_deframer_tb;
   import c8pd_pkg::*;

   // frame length of the block's default build
   localparam int FRAME_LEN    = 47;
   localparam int MAX_GAP      = 11;
   localparam int SETTLE       = 4;
   localparam int RANDOM_BYTES = 282;
   localparam int SETTINGS_N   = 6;
   localparam int LIMIT_NS     = 1_600_000;
   localparam logic [BYTE_W-1:0]      GEN_POLY   = 8'h4D;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   typedef enum logic {ROW_BYTE, ROW_WRITE} row_kind_type;

   // one row of the directed table; typed rows carry their own expected words
   typedef struct packed {
      row_kind_type           kind;
      logic [CSR_INDEX_W-1:0] reg_index;
      logic [BYTE_W-1:0]      value;
      logic                   typed;
      logic [1:0]             typed_n;
      rsp_type                typed0;
      rsp_type                typed1;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   c8pd_req_if req_bus ();
   c8pd_rsp_if rsp_bus ();
   c8pd_csr_if csr_bus ();

   // behavioural deframer state and its copy of the sync registers
   logic [BYTE_W-1:0] hdr_first  = SYNC_FIRST_RESET;
   logic [BYTE_W-1:0] hdr_second = SYNC_SECOND_RESET;
   phase_type         frame_phase = PH_HUNT;
   logic              first_armed = 1'b0;
   logic [BYTE_W-1:0] frame_pos = '0;
   logic [BYTE_W-1:0] frame_crc = '0;

   rsp_type      pending_words [$];
   stim_row_type directed_rows [$];
   int           error_count      = 0;
   int           frame_bytes_sent = 0;
   logic         steady_flow      = 1'b0;

   crc8_packet_deframer #(
      .FRAME_BYTES (FRAME_LEN)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // fold one byte into a CRC-8, shifting out the top bit each step
   function automatic logic [BYTE_W-1:0] crc8_fold(input logic [BYTE_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] acc;
      logic              msb;
      acc = crc ^ b;
      repeat (BYTE_W) begin
         msb = acc[BYTE_W-1];
         acc = acc << 1;
         if (msb) begin
            acc = acc ^ GEN_POLY;
         end
      end
      return acc;
   endfunction

   function automatic rsp_type word_of(input logic [BYTE_W-1:0] b, input logic [BYTE_W-1:0] idx,
                                       input logic last, input logic ok);
      rsp_type w;
      w.frame_byte = b;
      w.byte_index = idx;
      w.is_last    = last;
      w.crc_ok     = ok;
      return w;
   endfunction

   function automatic stim_row_type plain_row(input logic [BYTE_W-1:0] b);
      stim_row_type r;
      r       = '0;
      r.kind  = ROW_BYTE;
      r.value = b;
      return r;
   endfunction

   // idle cycles before the next word on either side
   function automatic int draw_idle();
      return steady_flow ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   // advance the deframer by one received byte, return the words it yields
   function automatic int deframe_byte(input logic [BYTE_W-1:0] b,
                                       output rsp_type w0, output rsp_type w1);
      int n;
      n  = 0;
      w0 = '0;
      w1 = '0;
      case (frame_phase)
         PH_BODY: begin
            w0          = word_of(b, frame_pos, 1'b0, 1'b0);
            frame_crc   = crc8_fold(frame_crc, b);
            frame_pos   = frame_pos + 8'd1;
            frame_phase = (frame_pos >= FRAME_LEN - 1) ? PH_CRC : PH_BODY;
            n           = 1;
         end
         PH_CRC: begin
            w0          = word_of(b, frame_pos, 1'b1, frame_crc == b);
            frame_phase = PH_HUNT;
            first_armed = 1'b0;
            frame_pos   = '0;
            frame_crc   = '0;
            n           = 1;
         end
         default: begin
            frame_phase = PH_HUNT;
            if (first_armed && b == hdr_second) begin
               // header complete: byte 0 is the sync_first value in force now
               w0          = word_of(hdr_first, 8'd0, 1'b0, 1'b0);
               w1          = word_of(b, 8'd1, 1'b0, 1'b0);
               frame_crc   = crc8_fold(crc8_fold(8'h00, hdr_first), b);
               frame_pos   = 8'd2;
               first_armed = 1'b0;
               frame_phase = (frame_pos >= FRAME_LEN - 1) ? PH_CRC : PH_BODY;
               n           = 2;
            end else begin
               first_armed = (b == hdr_first);
            end
         end
      endcase
      return n;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      error_count++;
   endtask

   task automatic add_byte(input logic [BYTE_W-1:0] b);
      directed_rows.push_back(plain_row(b));
   endtask

   // queue filler body bytes up to the trailing CRC byte, folding each into crc
   task automatic add_fill(inout logic [BYTE_W-1:0] crc);
      logic [BYTE_W-1:0] v;
      for (int k = 0; k < FRAME_LEN - 4; k++) begin
         v   = BYTE_W'(k * 37 + 3);
         add_byte(v);
         crc = crc8_fold(crc, v);
      end
   endtask

   task automatic add_checked(input logic [BYTE_W-1:0] b, input logic [1:0] n,
                              input rsp_type w0, input rsp_type w1);
      stim_row_type r;
      r         = plain_row(b);
      r.typed   = 1'b1;
      r.typed_n = n;
      r.typed0  = w0;
      r.typed1  = w1;
      directed_rows.push_back(r);
   endtask

   task automatic add_write(input logic [CSR_INDEX_W-1:0] idx, input logic [BYTE_W-1:0] v);
      stim_row_type r;
      r           = '0;
      r.kind      = ROW_WRITE;
      r.reg_index = idx;
      r.value     = v;
      directed_rows.push_back(r);
   endtask

   // offer one byte, wait for it to be taken, queue the words it should yield
   task automatic send_row(input stim_row_type row);
      int      gap;
      int      n;
      rsp_type w0;
      rsp_type w1;
      gap = draw_idle();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= row.value;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      n = deframe_byte(row.value, w0, w1);
      if (row.typed) begin
         if (n != row.typed_n) begin
            report_mismatch($sformatf("byte %02h: table gives %0d words, deframer %0d",
                                      row.value, row.typed_n, n));
         end
         n  = row.typed_n;
         w0 = row.typed0;
         w1 = row.typed1;
      end
      if (n > 0) begin
         pending_words.push_back(w0);
      end
      if (n > 1) begin
         pending_words.push_back(w1);
      end
   endtask

   // hold off the sender until every expected word is out, then let the block settle
   task automatic quiesce();
      req_bus.valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [BYTE_W-1:0] v);
      quiesce();
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= v;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      csr_bus.valid <= 1'b0;
      case (idx)
         CSR_SYNC_FIRST:  hdr_first  = v;
         CSR_SYNC_SECOND: hdr_second = v;
         default: ;
      endcase
   endtask

   // result side: stall at random, check each word against the oldest expectation
   initial begin : word_checker
      int      stall;
      rsp_type got;
      rsp_type want;
      rsp_bus.ready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         stall = draw_idle();
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         got = word_of(rsp_bus.frame_byte, rsp_bus.byte_index, rsp_bus.is_last, rsp_bus.crc_ok);
         if (pending_words.size() == 0) begin
            report_mismatch($sformatf("unexpected word %02h/%0d/%0d/%0d", got.frame_byte,
                                      got.byte_index, got.is_last, got.crc_ok));
         end else begin
            want = pending_words.pop_front();
            if (got !== want) begin
               report_mismatch($sformatf("word got %02h/%0d/%0d/%0d want %02h/%0d/%0d/%0d",
                                         got.frame_byte, got.byte_index, got.is_last,
                                         got.crc_ok, want.frame_byte, want.byte_index,
                                         want.is_last, want.crc_ok));
            end
         end
      end
   end

   initial begin : stimulus
      logic [BYTE_W-1:0] crc;
      logic [BYTE_W-1:0] b;
      logic [BYTE_W-1:0] nf;
      logic [BYTE_W-1:0] ns;
      int                setting;
      int                goal;
      req_bus.valid   = 1'b0;
      req_bus.rx_byte = '0;
      csr_bus.valid   = 1'b0;
      csr_bus.index   = CSR_SYNC_FIRST;
      csr_bus.data    = '0;

      // stray second byte, then a false start re-armed by a repeated first byte
      add_checked(8'h2C, 2'd0, '0, '0);
      add_checked(8'h54, 2'd0, '0, '0);
      add_checked(8'h54, 2'd0, '0, '0);
      add_checked(8'h2C, 2'd2, word_of(8'h54, 8'd0, 1'b0, 1'b0),
                  word_of(8'h2C, 8'd1, 1'b0, 1'b0));
      add_checked(8'h00, 2'd1, word_of(8'h00, 8'd2, 1'b0, 1'b0), '0);
      crc = crc8_fold(crc8_fold(crc8_fold(8'h00, 8'h54), 8'h2C), 8'h00);
      add_fill(crc);
      add_byte(crc);
      // a CRC byte equal to sync_first must not open a header
      add_byte(8'h54);
      add_byte(8'h2C);
      add_byte(8'hFF);
      crc = '0;
      add_fill(crc);
      add_byte(8'h54);
      add_checked(8'h2C, 2'd0, '0, '0);
      // extreme sync values
      add_write(CSR_SYNC_FIRST, 8'h00);
      add_write(CSR_SYNC_SECOND, 8'hFF);
      add_checked(8'h00, 2'd0, '0, '0);
      add_checked(8'hFF, 2'd2, word_of(8'h00, 8'd0, 1'b0, 1'b0),
                  word_of(8'hFF, 8'd1, 1'b0, 1'b0));
      add_byte(8'hFF);
      crc = crc8_fold(crc8_fold(crc8_fold(8'h00, 8'h00), 8'hFF), 8'hFF);
      add_fill(crc);
      add_byte(crc);
      add_write(CSR_SYNC_FIRST, 8'hFF);
      add_write(CSR_SYNC_SECOND, 8'h00);
      add_write(CSR_UNUSED, 8'hA5);
      // armed state survives a write; the header then matches the new second byte
      add_byte(8'hFF);
      add_write(CSR_SYNC_SECOND, 8'h11);
      add_checked(8'h11, 2'd2, word_of(8'hFF, 8'd0, 1'b0, 1'b0),
                  word_of(8'h11, 8'd1, 1'b0, 1'b0));
      add_byte(8'hA5);
      crc = crc8_fold(crc8_fold(crc8_fold(8'h00, 8'hFF), 8'h11), 8'hA5);
      add_fill(crc);
      // registers rewritten mid-frame: the frame runs on, here with a bad CRC
      add_write(CSR_SYNC_FIRST, SYNC_FIRST_RESET);
      add_write(CSR_SYNC_SECOND, SYNC_SECOND_RESET);
      add_byte(crc ^ 8'h80);
      // byte 0 of a header is the sync_first value in force when it completes
      add_byte(8'h54);
      add_write(CSR_SYNC_FIRST, 8'h77);
      add_checked(8'h2C, 2'd2, word_of(8'h77, 8'd0, 1'b0, 1'b0),
                  word_of(8'h2C, 8'd1, 1'b0, 1'b0));
      add_byte(8'h00);
      crc = crc8_fold(crc8_fold(crc8_fold(8'h00, 8'h77), 8'h2C), 8'h00);
      add_fill(crc);
      add_byte(crc);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            write_reg(directed_rows[i].reg_index, directed_rows[i].value);
         end else begin
            send_row(directed_rows[i]);
         end
      end

      // random frames and noise under a sequence of sync settings
      for (setting = 0; setting < SETTINGS_N; setting++) begin
         case (setting)
            0: begin
               nf = SYNC_FIRST_RESET;
               ns = SYNC_SECOND_RESET;
            end
            1: begin
               nf = 8'h00;
               ns = 8'hFF;
            end
            2: begin
               nf = 8'hFF;
               ns = 8'h00;
            end
            3: begin
               nf = BYTE_W'($urandom_range(0, 255));
               ns = nf;
            end
            default: begin
               nf = BYTE_W'($urandom_range(0, 255));
               ns = BYTE_W'($urandom_range(0, 255));
            end
         endcase
         write_reg(CSR_SYNC_FIRST, nf);
         write_reg(CSR_SYNC_SECOND, ns);
         goal = frame_bytes_sent + RANDOM_BYTES / SETTINGS_N;
         while (frame_bytes_sent < goal) begin
            steady_flow = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 3) != 0) begin
               // well-formed frame with random body, CRC usually right
               send_row(plain_row(hdr_first));
               send_row(plain_row(hdr_second));
               crc = crc8_fold(crc8_fold(8'h00, hdr_first), hdr_second);
               repeat (FRAME_LEN - 3) begin
                  b = BYTE_W'($urandom_range(0, 255));
                  send_row(plain_row(b));
                  crc = crc8_fold(crc, b);
               end
               if ($urandom_range(0, 3) == 0) begin
                  b   = BYTE_W'($urandom_range(1, 255));
                  crc = crc ^ b;
               end
               send_row(plain_row(crc));
               frame_bytes_sent += FRAME_LEN;
            end else begin
               // noise: false starts, broken headers, random bytes
               repeat ($urandom_range(1, 4)) begin
                  case ($urandom_range(0, 3))
                     0:       b = hdr_first;
                     1:       b = hdr_second;
                     default: b = BYTE_W'($urandom_range(0, 255));
                  endcase
                  send_row(plain_row(b));
               end
            end
         end
      end
      steady_flow = 1'b0;

      quiesce();
      if (error_count == 0) begin
         $display("crc8_packet_deframer verification clean");
      end else begin
         $display("crc8_packet_deframer verification failed");
      end
      $finish;
   end

   initial begin : watchdog
      #(LIMIT_NS);
      $display("crc8_packet_deframer verification failed");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/c8pd_pkg.sv
rtl/c8pd_channels.sv
rtl/c8pd_rsp_queue.sv
rtl/crc8_packet_deframer.sv
tb/sv/crc8_packet_deframer_tb.sv
